// ===== src/assert_macros.svh =====
// Assertion macros for the RTL of the sorted group sum/average block.
// No dependencies; expects clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never hold outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    `ASSERT_CLK(label, !(cond), msg)

`endif

// ===== src/sgsa_pkg.sv =====
// Package for the sorted group sum/average block: item types, widths,
// command/status structs and the count clamp. No dependencies.
package sgsa_pkg;

    localparam int COUNT_BITS = 24;
    localparam int KEY_W      = 64;
    localparam int VAL_W      = 32;
    localparam int SUM_W      = 48;
    localparam int AVG_W      = 32;
    localparam int CNT_OUT_W  = 24;
    localparam int DIV_CNT_W  = $clog2(SUM_W + 1);
    localparam int CMP_W      = (COUNT_BITS > CNT_OUT_W) ? COUNT_BITS : CNT_OUT_W;
    localparam logic [CNT_OUT_W-1:0] CNT_OUT_MAX = '1;

    typedef struct packed {
        logic [KEY_W-1:0] record_key;
        logic [VAL_W-1:0] revenue;
        logic [VAL_W-1:0] rank_value;
        logic             final_record;
    } in_item_t;

    typedef struct packed {
        logic [KEY_W-1:0]     group_key;
        logic [SUM_W-1:0]     revenue_total;
        logic [AVG_W-1:0]     rank_average;
        logic [CNT_OUT_W-1:0] member_count;
        logic                 run_end;
    } out_item_t;

    typedef struct packed {
        logic load_item;
        logic check;
        logic final_snap;
        logic div_step;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic key_differs;
        logic item_final;
        logic div_done;
    } dp_status_t;

    function automatic logic [CNT_OUT_W-1:0] sat_count(input logic [COUNT_BITS-1:0] c);
        logic [CMP_W-1:0] w;
        w = CMP_W'(c);
        if (w > CMP_W'(CNT_OUT_MAX))
            return CNT_OUT_MAX;
        return CNT_OUT_W'(w);
    endfunction

endpackage

// ===== src/sgsa_datapath.sv =====
// Datapath: item register, group accumulators, snapshot, radix-2 divider
// and output register. Depends on sgsa_pkg.
module sgsa_datapath
    import sgsa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  in_item_t   record,
    input  dp_cmd_t    cmd,
    output dp_status_t status,
    output out_item_t  group
);

    in_item_t              item_reg;
    logic [KEY_W-1:0]      open_key_reg;
    logic [SUM_W-1:0]      rev_acc_reg;
    logic [SUM_W-1:0]      rank_acc_reg;
    logic [COUNT_BITS-1:0] cnt_reg;
    logic                  open_reg;
    logic                  open_next;

    logic [KEY_W-1:0]      snap_key_reg;
    logic [SUM_W-1:0]      snap_rev_reg;
    logic [COUNT_BITS-1:0] snap_cnt_reg;
    logic                  snap_end_reg;
    logic [SUM_W-1:0]      quo_reg;
    logic [SUM_W-1:0]      quo_next;
    logic [COUNT_BITS-1:0] rem_reg;
    logic [COUNT_BITS-1:0] rem_next;
    logic [DIV_CNT_W-1:0]  div_cnt_reg;
    logic [DIV_CNT_W-1:0]  div_cnt_next;

    out_item_t             out_reg;

    logic                  differs;
    logic                  start_new;
    logic                  snap_any;
    logic [SUM_W:0]        rev_sum;
    logic [SUM_W:0]        rank_sum;
    logic [COUNT_BITS:0]   rem_shift;
    logic [COUNT_BITS:0]   rem_diff;
    logic                  quo_bit;

    assign differs   = open_reg && (item_reg.record_key != open_key_reg);
    assign start_new = !open_reg || differs;
    assign snap_any  = (cmd.check && differs) || cmd.final_snap;

    assign rev_sum  = {1'b0, rev_acc_reg} + (SUM_W + 1)'(item_reg.revenue);
    assign rank_sum = {1'b0, rank_acc_reg} + (SUM_W + 1)'(item_reg.rank_value);

    assign rem_shift = {rem_reg, quo_reg[SUM_W-1]};
    assign rem_diff  = rem_shift - {1'b0, snap_cnt_reg};
    assign quo_bit   = (rem_shift >= {1'b0, snap_cnt_reg});
    assign rem_next  = quo_bit ? rem_diff[COUNT_BITS-1:0] : rem_shift[COUNT_BITS-1:0];
    assign quo_next  = {quo_reg[SUM_W-2:0], quo_bit};

    always_comb
    begin
        open_next = open_reg;
        if (cmd.check)
            open_next = 1'b1;
        else if (cmd.final_snap)
            open_next = 1'b0;
    end

    always_comb
    begin
        div_cnt_next = div_cnt_reg;
        if (snap_any)
            div_cnt_next = DIV_CNT_W'(SUM_W);
        else if (cmd.div_step && (div_cnt_reg != '0))
            div_cnt_next = div_cnt_reg - DIV_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg    <= 1'b0;
            div_cnt_reg <= '0;
        end
        else
        begin
            open_reg    <= open_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
            item_reg <= record;

        if (cmd.check)
        begin
            if (start_new)
            begin
                open_key_reg <= item_reg.record_key;
                rev_acc_reg  <= SUM_W'(item_reg.revenue);
                rank_acc_reg <= SUM_W'(item_reg.rank_value);
                cnt_reg      <= COUNT_BITS'(1);
            end
            else
            begin
                rev_acc_reg  <= rev_sum[SUM_W] ? '1 : rev_sum[SUM_W-1:0];
                rank_acc_reg <= rank_sum[SUM_W] ? '1 : rank_sum[SUM_W-1:0];
                if (cnt_reg != '1)
                    cnt_reg <= cnt_reg + COUNT_BITS'(1);
            end
        end

        if (snap_any)
        begin
            snap_key_reg <= open_key_reg;
            snap_rev_reg <= rev_acc_reg;
            snap_cnt_reg <= cnt_reg;
            snap_end_reg <= cmd.final_snap || !item_reg.final_record;
            quo_reg      <= rank_acc_reg;
            rem_reg      <= '0;
        end
        else if (cmd.div_step && (div_cnt_reg != '0))
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end

        if (cmd.out_load)
        begin
            out_reg.group_key     <= snap_key_reg;
            out_reg.revenue_total <= snap_rev_reg;
            out_reg.rank_average  <= (|quo_reg[SUM_W-1:AVG_W]) ? '1 : quo_reg[AVG_W-1:0];
            out_reg.member_count  <= sat_count(snap_cnt_reg);
            out_reg.run_end       <= snap_end_reg;
        end
    end

    assign status.key_differs = differs;
    assign status.item_final  = item_reg.final_record;
    assign status.div_done    = (div_cnt_reg == '0);
    assign group              = out_reg;

endmodule

// ===== src/sgsa_ctrl.sv =====
// Controller: item sequencing state machine and output valid flag.
// Depends on sgsa_pkg.
module sgsa_ctrl
    import sgsa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       record_valid,
    output logic       record_ready,
    output logic       group_valid,
    input  logic       group_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CHECK = 4'b0010,
        S_FLOAD = 4'b0100,
        S_DIV   = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   fin_pend_reg;
    logic   fin_pend_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || group_ready;

    always_comb
    begin
        state_next    = state_reg;
        fin_pend_next = fin_pend_reg;
        cmd           = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.load_item = record_valid;
                if (record_valid)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.check = 1'b1;
                if (status.key_differs)
                begin
                    fin_pend_next = status.item_final;
                    state_next    = S_DIV;
                end
                else if (status.item_final)
                    state_next = S_FLOAD;
                else
                    state_next = S_IDLE;
            end
            S_FLOAD:
            begin
                cmd.final_snap = 1'b1;
                fin_pend_next  = 1'b0;
                state_next     = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done && out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = fin_pend_reg ? S_FLOAD : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (group_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fin_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fin_pend_reg  <= fin_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign record_ready = (state_reg == S_IDLE);
    assign group_valid  = out_valid_reg;

endmodule

// ===== src/sorted_group_sum_average.sv =====
// Top level of the sorted group sum/average block: controller plus datapath.
// Depends on sgsa_pkg, sgsa_ctrl, sgsa_datapath and assert_macros.svh.
//
//   channel  | handshake                   | payload
//   record   | record_valid / record_ready | in_item_t  (one sorted record)
//   group    | group_valid  / group_ready  | out_item_t (one finished group)
//
// An item that closes no group passes the idle and check states. Each group
// closed adds the divider steps, one per bit of the rank sum, then the output
// load, plus the final-load state when a final record closes it.
// Reset clears the group-open flag, the state machine and the output valid.
// The output register lets the next item in while a group waits; a stalled
// output holds the divider until the register is free.
`include "assert_macros.svh"

module sorted_group_sum_average
    import sgsa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      record_valid,
    output logic      record_ready,
    input  in_item_t  record,
    output logic      group_valid,
    input  logic      group_ready,
    output out_item_t group
);

    dp_cmd_t    cmd;
    dp_status_t status;

    sgsa_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .record_valid (record_valid),
        .record_ready (record_ready),
        .group_valid  (group_valid),
        .group_ready  (group_ready),
        .status       (status),
        .cmd          (cmd)
    );

    sgsa_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .record (record),
        .cmd    (cmd),
        .status (status),
        .group  (group)
    );

    `ASSERT_CLK(a_busy_after_item, record_valid && record_ready |=> !record_ready, "still ready")
    `ASSERT_NEVER(a_count_nonzero, group_valid && (group.member_count == '0), "empty group emitted")
    `ASSERT_NEVER(a_pending_final, group_valid && !group.run_end && record_ready, "final group lost")
    `ASSERT_CLK(a_load_when_free, cmd.out_load |-> (!group_valid || group_ready), "output overwritten")

endmodule

// ===== tb/sorted_group_sum_average_checker.sv =====
// Checker for the sorted group sum/average block: watches both channels, keeps its own
// copy of the open group and compares each finished group with the one it predicted.
// Depends on sgsa_pkg.
`timescale 1ns / 1ps

module sorted_group_sum_average_checker
    import sgsa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      record_valid,
    input  logic      record_ready,
    input  in_item_t  record,
    input  logic      group_valid,
    input  logic      group_ready,
    input  out_item_t group,
    output int        fail_count,
    output int        pending
);

    localparam int MAX_REPORTS = 200;

    out_item_t expected_groups [$];
    int        errors = 0;

    logic [KEY_W-1:0]      open_key;
    logic [SUM_W-1:0]      revenue_sum;
    logic [SUM_W-1:0]      rank_sum;
    logic [COUNT_BITS-1:0] members;
    logic                  group_is_open;

    assign fail_count = errors;

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("ERROR %0t ns: %s got %0h want %0h", $time, field, got, want);
    endtask

    function automatic logic [SUM_W-1:0] add_sat(input logic [SUM_W-1:0] a,
                                                 input logic [VAL_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + (SUM_W + 1)'(b);
        return s[SUM_W] ? '1 : s[SUM_W-1:0];
    endfunction

    function automatic out_item_t closed_group();
        out_item_t        g;
        logic [SUM_W-1:0] quot;
        quot = rank_sum / SUM_W'(members);
        g.group_key     = open_key;
        g.revenue_total = revenue_sum;
        g.rank_average  = (quot > SUM_W'({AVG_W{1'b1}})) ? '1 : quot[AVG_W-1:0];
        g.member_count  = (64'(members) > 64'(CNT_OUT_MAX)) ? CNT_OUT_MAX
                                                             : CNT_OUT_W'(members);
        g.run_end       = 1'b0;
        return g;
    endfunction

    task automatic fold_record(input in_item_t r);
        out_item_t done [$];
        if (group_is_open && r.record_key != open_key) begin
            done.push_back(closed_group());
            group_is_open = 1'b0;
        end
        if (group_is_open) begin
            revenue_sum = add_sat(revenue_sum, r.revenue);
            rank_sum    = add_sat(rank_sum, r.rank_value);
            if (members != '1)
                members++;
        end
        else begin
            open_key      = r.record_key;
            revenue_sum   = SUM_W'(r.revenue);
            rank_sum      = SUM_W'(r.rank_value);
            members       = 1;
            group_is_open = 1'b1;
        end
        if (r.final_record) begin
            done.push_back(closed_group());
            group_is_open = 1'b0;
        end
        if (done.size() > 0)
            done[done.size() - 1].run_end = 1'b1;
        foreach (done[i])
            expected_groups.push_back(done[i]);
    endtask

    task automatic check_group(input out_item_t got);
        out_item_t want;
        if (expected_groups.size() == 0) begin
            report_mismatch("unexpected group, group_key", got.group_key, '0);
            return;
        end
        want = expected_groups.pop_front();
        if (got.group_key != want.group_key)
            report_mismatch("group_key", got.group_key, want.group_key);
        if (got.revenue_total != want.revenue_total)
            report_mismatch("revenue_total", got.revenue_total, want.revenue_total);
        if (got.rank_average != want.rank_average)
            report_mismatch("rank_average", got.rank_average, want.rank_average);
        if (got.member_count != want.member_count)
            report_mismatch("member_count", got.member_count, want.member_count);
        if (got.run_end != want.run_end)
            report_mismatch("run_end", got.run_end, want.run_end);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_key      = '0;
            revenue_sum   = '0;
            rank_sum      = '0;
            members       = '0;
            group_is_open = 1'b0;
            expected_groups.delete();
            pending <= 0;
        end
        else
        begin
            if (record_valid && record_ready)
                fold_record(record);
            if (group_valid && group_ready)
                check_group(group);
            pending <= expected_groups.size();
        end
    end

endmodule

// ===== tb/sorted_group_sum_average_tb.sv =====
// Testbench top for the sorted group sum/average block: clock, reset, record stimulus
// and group-side back-pressure; checking is left to sorted_group_sum_average_checker.
// Depends on sgsa_pkg, the block and the checker.
`timescale 1ns / 1ps

module sorted_group_sum_average_tb;
    import sgsa_pkg::*;

    localparam int  RANDOM_ITEMS = 750;
    localparam int  QUIET_ITEMS  = 100;
    localparam int  HOLD_CYCLES  = 600;
    localparam int  DRAIN_CYCLES = 150;
    localparam time TIMEOUT_NS   = 8_000_000;

    logic      clk          = 1'b0;
    logic      rst_n        = 1'b0;
    logic      record_valid = 1'b0;
    logic      record_ready;
    in_item_t  record       = '0;
    logic      group_valid;
    logic      group_ready  = 1'b0;
    out_item_t group;

    int fail_count;
    int pending;
    bit idle_en   = 1'b1;
    bit stall_en  = 1'b1;
    bit long_hold = 1'b0;

    always #4 clk = ~clk;

    sorted_group_sum_average i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .record_valid (record_valid),
        .record_ready (record_ready),
        .record       (record),
        .group_valid  (group_valid),
        .group_ready  (group_ready),
        .group        (group)
    );

    sorted_group_sum_average_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .record_valid (record_valid),
        .record_ready (record_ready),
        .record       (record),
        .group_valid  (group_valid),
        .group_ready  (group_ready),
        .group        (group),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    task automatic send(input logic [KEY_W-1:0] key, input logic [VAL_W-1:0] rev,
                        input logic [VAL_W-1:0] rank, input logic fin);
        if (idle_en && $urandom_range(0, 5) == 0) begin
            record_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        record       <= '{record_key: key, revenue: rev, rank_value: rank, final_record: fin};
        record_valid <= 1'b1;
        @(posedge clk);
        while (!record_ready)
            @(posedge clk);
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return VAL_W'($urandom_range(0, 16));
            default: return $urandom;
        endcase
    endfunction

    // group side: random ready bursts, plus one long hold-off on request
    initial
    begin
        wait (rst_n);
        @(posedge clk);
        forever begin
            if (long_hold) begin
                group_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                long_hold = 1'b0;
            end
            else begin
                group_ready <= !(stall_en && $urandom_range(0, 2) == 0);
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] k;
        logic             fin;
        int               sent;
        int               n_groups;
        int               size;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: key zero from reset, final with nothing open, extremes, near keys
        send('0, '0, '0, 1'b1);
        send('1, '1, '1, 1'b0);
        send('1, '1, '1, 1'b0);
        send({1'b0, {63{1'b1}}}, '0, 32'd5, 1'b0);
        send({{63{1'b1}}, 1'b0}, 32'h0001_0000, 32'd5, 1'b0);
        send({{63{1'b1}}, 1'b0}, 32'h0000_8000, '0, 1'b0);
        send({{63{1'b1}}, 1'b0}, '0, '0, 1'b1);
        send(64'd1, 32'h1234_5678, 32'h0002_0000, 1'b0);
        send(64'd2, '1, 32'd1, 1'b1);
        send(64'd2, '0, '0, 1'b1);
        send('0, 32'h0000_0001, 32'h0000_0003, 1'b0);
        send('0, 32'h8000_0000, 32'h0000_0002, 1'b1);

        // receiver holds off while one-record groups keep coming
        idle_en   = 1'b0;
        long_hold = 1'b1;
        for (int i = 0; i < 16; i++)
            send(64'h100 + 64'(i), pick_value(), pick_value(), i == 15);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            key      = ($urandom_range(0, 9) == 0) ? '0 : {$urandom, $urandom};
            n_groups = $urandom_range(1, 10);
            for (int g = 0; g < n_groups; g++) begin
                size = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 24)
                                                   : $urandom_range(1, 3);
                for (int m = 0; m < size; m++) begin
                    if (g == n_groups - 1 && m == size - 1)
                        fin = ($urandom_range(0, 7) != 0);
                    else
                        fin = ($urandom_range(0, 39) == 0);
                    k        = ($urandom_range(0, 49) == 0) ? {$urandom, $urandom} : key;
                    idle_en  = (sent < RANDOM_ITEMS - QUIET_ITEMS);
                    stall_en = idle_en;
                    send(k, pick_value(), pick_value(), fin);
                    sent++;
                end
                if ($urandom_range(0, 1) == 0)
                    key = key + 64'($urandom_range(1, 4));
                else
                    key = key + ({$urandom, $urandom} >> $urandom_range(4, 62));
            end
        end

        // close whatever group is still open
        send({$urandom, $urandom}, pick_value(), pick_value(), 1'b1);
        record_valid <= 1'b0;
        @(posedge clk);

        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/sgsa_pkg.sv
src/sgsa_datapath.sv
src/sgsa_ctrl.sv
src/sorted_group_sum_average.sv
tb/sorted_group_sum_average_checker.sv
tb/sorted_group_sum_average_tb.sv
